// ===== sv/gevt_pkg.sv =====
// gevt_pkg: types, codes and tables of the gamepad event translator
// used by gevt_decode and the top level; depends on nothing
`default_nettype none

package gevt_pkg;

   // size defaults and the largest button index width in the range
   localparam int DEF_NUM_PADS    = 4;
   localparam int DEF_NUM_BUTTONS = 32;
   localparam int MAX_BTN_W       = 6;

   // configuration register indexes
   localparam logic [1:0] CSR_KEY_OFFSET = 2'd0;
   localparam logic [1:0] CSR_STICK_THR  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   // configuration reset values
   localparam logic [9:0]  RST_KEY_OFFSET = 10'd300;
   localparam logic [14:0] RST_STICK_THR  = 15'd16383;
   localparam logic [31:0] RST_TIMEOUT    = 32'd100000000;

   // result action codes
   localparam logic [1:0] ACT_RELEASED = 2'd0;
   localparam logic [1:0] ACT_PRESSED  = 2'd1;
   localparam logic [1:0] ACT_REPEAT   = 2'd2;

   // button code meaning no d-pad button yet
   localparam logic [4:0] BTN_NONE = 5'd31;

   // event classes and axis codes
   localparam logic [4:0] EV_KEY = 5'd1;
   localparam logic [4:0] EV_ABS = 5'd3;
   localparam logic [9:0] AX_X     = 10'd0;
   localparam logic [9:0] AX_Y     = 10'd1;
   localparam logic [9:0] AX_RX    = 10'd3;
   localparam logic [9:0] AX_RY    = 10'd4;
   localparam logic [9:0] AX_HAT_X = 10'd16;
   localparam logic [9:0] AX_HAT_Y = 10'd17;

   // one request
   typedef struct packed {
      logic               kind;
      logic [1:0]         pad;
      logic [63:0]        time_ns;
      logic [4:0]         event_type;
      logic [9:0]         event_code;
      logic signed [15:0] event_value;
   } req_type;

   // one result
   typedef struct packed {
      logic [4:0] button;
      logic [1:0] action;
   } rsp_type;

   // translated event, decoder to control
   typedef struct packed {
      logic                 emit;
      logic [MAX_BTN_W-1:0] idx;
      logic [4:0]           button;
      logic [1:0]           action;
      logic                 dpad_we;
      logic [4:0]           dpad_btn;
      logic                 stick_we;
      logic [1:0]           stick_slot;
      logic [4:0]           stick_btn;
   } dec_type;

   // stick direction buttons per axis slot: negative or positive side
   function automatic logic [4:0] stick_button(input logic [1:0] slot, input logic pos);
      logic [4:0] b;
      case (slot)
         2'd0:    b = pos ? 5'd20 : 5'd19;
         2'd1:    b = pos ? 5'd22 : 5'd21;
         2'd2:    b = pos ? 5'd25 : 5'd24;
         default: b = pos ? 5'd27 : 5'd26;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== sv/gevt_ram.sv =====
// gevt_ram: generic single port ram with registered read
// depends on nothing
`default_nettype none

module gevt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, and a registered read of the addressed entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/gevt_decode.sv =====
// gevt_decode: turns one raw key or axis event into a button event
// depends on gevt_pkg
`default_nettype none

module gevt_decode #(
   parameter int NUM_BUTTONS = 32
) (
   input  wire gevt_pkg::req_type  req,
   input  wire logic [9:0]         key_offset,
   input  wire logic [14:0]        stick_thr,
   input  wire logic [3:0][4:0]    stick_last,
   input  wire logic [4:0]         dpad_last,
   output gevt_pkg::dec_type       dec
);
   import gevt_pkg::*;

   logic [9:0]         key_btn;
   logic signed [16:0] val_s;
   logic signed [16:0] thr_s;
   logic               is_stick;
   logic [1:0]         slot;
   logic [4:0]         hat_btn;

   // key button number, sign-extended stick value and zero-extended threshold
   assign key_btn = req.event_code - key_offset;
   assign val_s   = {req.event_value[15], req.event_value};
   assign thr_s   = {2'b00, stick_thr};

   // stick axis slot
   always_comb begin
      is_stick = 1'b1;
      slot     = 2'd0;
      case (req.event_code)
         AX_X:    slot = 2'd0;
         AX_Y:    slot = 2'd1;
         AX_RX:   slot = 2'd2;
         AX_RY:   slot = 2'd3;
         default: is_stick = 1'b0;
      endcase
   end

   // hat press: horizontal 0/1, vertical 2/3, value one is the positive side
   always_comb begin
      hat_btn[4:2] = 3'd0;
      hat_btn[1]   = (req.event_code == AX_HAT_Y);
      hat_btn[0]   = (req.event_value == 16'sd1);
   end

   // translation
   always_comb begin
      dec            = '0;
      dec.stick_slot = slot;
      if (req.event_type == EV_KEY) begin
         if ((req.event_code >= key_offset) && (key_btn < 10'(NUM_BUTTONS)) &&
             (req.event_value >= 16'sd0) && (req.event_value <= 16'sd2)) begin
            dec.emit   = 1'b1;
            dec.idx    = key_btn[MAX_BTN_W-1:0];
            dec.button = key_btn[4:0];
            dec.action = req.event_value[1:0];
         end
      end else if (req.event_type == EV_ABS) begin
         if ((req.event_code == AX_HAT_X) || (req.event_code == AX_HAT_Y)) begin
            if (req.event_value == 16'sd0) begin
               // hat release reports the last d-pad press, if any
               if (dpad_last != BTN_NONE) begin
                  dec.emit   = 1'b1;
                  dec.button = dpad_last;
                  dec.action = ACT_RELEASED;
               end
            end else begin
               dec.emit     = 1'b1;
               dec.button   = hat_btn;
               dec.action   = ACT_PRESSED;
               dec.dpad_we  = 1'b1;
               dec.dpad_btn = hat_btn;
            end
         end else if (is_stick) begin
            dec.emit = 1'b1;
            if (val_s > thr_s) begin
               dec.button    = stick_button(slot, 1'b1);
               dec.action    = ACT_PRESSED;
               dec.stick_we  = 1'b1;
               dec.stick_btn = stick_button(slot, 1'b1);
            end else if (val_s < -thr_s) begin
               dec.button    = stick_button(slot, 1'b0);
               dec.action    = ACT_PRESSED;
               dec.stick_we  = 1'b1;
               dec.stick_btn = stick_button(slot, 1'b0);
            end else begin
               dec.button = stick_last[slot];
               dec.action = ACT_RELEASED;
            end
         end
         dec.idx = MAX_BTN_W'(dec.button);
      end
   end

endmodule

`default_nettype wire

// ===== sv/gamepad_event_translator_with_repeat.sv =====
// gamepad_event_translator_with_repeat: top level, control and press-time store
// depends on gevt_pkg, gevt_ram and gevt_decode
//
//   channel   ports                               handshake
//   request   start, busy, req_data               taken when start and not busy
//   result    rsp_strobe, rsp_data                one cycle, cannot be held off
//   config    csr_valid, csr_ready, csr_index,    taken when valid and ready
//             csr_data
//
// an event request is captured, decoded and its result registered, if it gives one; a tick
// walks the pad's press times through the single ram port, one per cycle, and reports the
// first button whose stamp is older than the timeout as a repeat, restamping it, or gives
// no result. after reset a clearing pass writes every ram entry once, 2**(pad bits +
// button bits) entries (128 at the defaults), with busy high.
// configuration writes are always taken.
`default_nettype none

module gamepad_event_translator_with_repeat #(
   parameter int NUM_PADS    = gevt_pkg::DEF_NUM_PADS,
   parameter int NUM_BUTTONS = gevt_pkg::DEF_NUM_BUTTONS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire gevt_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output gevt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import gevt_pkg::*;

   localparam int PAD_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
   localparam int BTN_W = $clog2(NUM_BUTTONS);
   localparam int CNT_W = BTN_W + 1;
   localparam int AW    = PAD_W + BTN_W;
   localparam int DEPTH = 2 ** AW;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVENT,
      ST_SCAN
   } state_type;

   state_type        state_ff;
   logic [AW-1:0]    clr_idx_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic             chk_valid_ff;
   logic [BTN_W-1:0] chk_idx_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_data_ff;
   req_type          req_ff;
   logic [3:0][4:0]  stick_ff;
   logic [4:0]       dpad_ff;
   logic [9:0]       key_offset_ff;
   logic [14:0]      stick_thr_ff;
   logic [31:0]      timeout_ff;

   logic             accept;
   logic [PAD_W-1:0] pad_sel;
   logic             scan_issue;
   logic             scan_hit;
   logic             scan_last;
   logic [63:0]      elapsed;
   dec_type          dec;
   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [63:0]      ram_wdata;
   logic [63:0]      ram_rdata;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign pad_sel   = PAD_W'(req_ff.pad);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_offset_ff <= RST_KEY_OFFSET;
         stick_thr_ff  <= RST_STICK_THR;
         timeout_ff    <= RST_TIMEOUT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_OFFSET: key_offset_ff <= csr_data[9:0];
            CSR_STICK_THR:  stick_thr_ff  <= csr_data[14:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_data;
            default:        ;
         endcase
      end
   end

   // event translation
   gevt_decode #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_decode (
      .req        (req_ff),
      .key_offset (key_offset_ff),
      .stick_thr  (stick_thr_ff),
      .stick_last (stick_ff),
      .dpad_last  (dpad_ff),
      .dec        (dec)
   );

   // repeat check on the press time returned by the ram
   assign elapsed    = req_ff.time_ns - ram_rdata;
   assign scan_hit   = chk_valid_ff && (ram_rdata != 64'd0) && (elapsed > {32'd0, timeout_ff});
   assign scan_last  = chk_valid_ff && (chk_idx_ff == BTN_W'(NUM_BUTTONS - 1));
   assign scan_issue = (state_ff == ST_SCAN) && !scan_hit && !scan_last &&
                       (rd_idx_ff != CNT_W'(NUM_BUTTONS));

   // ram port: clear sweep, event stamp (zero when not a press), repeat restamp, else scan read
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = {pad_sel, rd_idx_ff[BTN_W-1:0]};
      ram_wdata = 64'd0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_idx_ff;
         end
         ST_EVENT: begin
            ram_we    = dec.emit;
            ram_addr  = {pad_sel, dec.idx[BTN_W-1:0]};
            ram_wdata = (dec.action == ACT_PRESSED) ? req_ff.time_ns : 64'd0;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               ram_we    = 1'b1;
               ram_addr  = {pad_sel, chk_idx_ff};
               ram_wdata = req_ff.time_ns;
            end
         end
         default: ;
      endcase
   end

   gevt_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_stamp_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // control sequence and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         rd_idx_ff     <= '0;
         chk_valid_ff  <= 1'b0;
         chk_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         stick_ff      <= {stick_button(2'd3, 1'b0), stick_button(2'd2, 1'b0),
                           stick_button(2'd1, 1'b0), stick_button(2'd0, 1'b0)};
         dpad_ff       <= BTN_NONE;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rd_idx_ff    <= '0;
               chk_valid_ff <= 1'b0;
               if (accept && (32'(req_data.pad) < 32'(NUM_PADS))) begin
                  state_ff <= req_data.kind ? ST_SCAN : ST_EVENT;
               end
            end
            ST_EVENT: begin
               rsp_strobe_ff      <= dec.emit;
               rsp_data_ff.button <= dec.button;
               rsp_data_ff.action <= dec.action;
               if (dec.dpad_we) begin
                  dpad_ff <= dec.dpad_btn;
               end
               if (dec.stick_we) begin
                  stick_ff[dec.stick_slot] <= dec.stick_btn;
               end
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               chk_valid_ff <= scan_issue;
               chk_idx_ff   <= rd_idx_ff[BTN_W-1:0];
               if (scan_issue) begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
               end
               if (scan_hit) begin
                  rsp_strobe_ff      <= 1'b1;
                  rsp_data_ff.button <= 5'(chk_idx_ff);
                  rsp_data_ff.action <= ACT_REPEAT;
                  state_ff           <= ST_IDLE;
               end else if (scan_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // a result only follows event or scan work
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_EVENT || $past(state_ff) == ST_SCAN))
      else $error("result strobe without event or scan work");

   // the clearing pass never takes requests
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy)
      else $error("request port open during clearing pass");

   // a checked stamp belongs to a button of the scanned pad
   a_chk_range: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (32'(chk_idx_ff) < 32'(NUM_BUTTONS)))
      else $error("scan checked a button beyond the button count");

endmodule

`default_nettype wire
